// ----- sv/torus_vertex_generator_core_defines.svh -----
// ---------------------------------------------------------------------------
// Torus vertex generator assertion macros
// Shared concurrent assertion forms clocked on aclk.
// ---------------------------------------------------------------------------
`ifndef TORUS_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define TORUS_VERTEX_GENERATOR_CORE_DEFINES_SVH

// Check a property outside reset.
`define TVG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TVG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/tvg_pkg.sv -----
// ---------------------------------------------------------------------------
// Torus vertex generator package
// Stage types, constants and step functions of the vertex pipeline.
// ---------------------------------------------------------------------------
package tvg_pkg;

    localparam int PHASE_BITS   = 32;
    localparam int UV_BITS      = 16;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [31:0]        EIGHTH_TURN = 32'h2000_0000;

    localparam logic [1:0] REG_MAJOR_RADIUS  = 2'd0;
    localparam logic [1:0] REG_MINOR_RADIUS  = 2'd1;
    localparam logic [1:0] REG_RING_SEGMENTS = 2'd2;
    localparam logic [1:0] REG_TUBE_SEGMENTS = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

    typedef struct packed {
        logic [10:0]           rem_ph;
        logic [PHASE_BITS-1:0] q_ph;
        logic [10:0]           rem_uv;
        logic [UV_BITS:0]      q_uv;
    } div_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic [1:0]         quad;
    } cord_t;

    typedef struct packed {
        logic signed [15:0] cp;
        logic signed [15:0] sp;
        logic signed [15:0] ct;
        logic signed [15:0] st;
    } trig_t;

    typedef struct packed {
        logic [16:0] u;
        logic [16:0] v;
        logic [20:0] vn;
    } side_t;

    typedef struct packed {
        logic signed [32:0] ring;
        logic signed [15:0] cp;
        logic signed [15:0] sp;
        logic signed [15:0] st;
        logic signed [31:0] nx_p;
        logic signed [31:0] nz_p;
        logic signed [32:0] py_p;
    } pa_t;

    function automatic logic [31:0] atan_turn(input int unsigned i);
        case (i)
            0:  return 32'd536870912;
            1:  return 32'd316933406;
            2:  return 32'd167458907;
            3:  return 32'd85004756;
            4:  return 32'd42667331;
            5:  return 32'd21354465;
            6:  return 32'd10679838;
            7:  return 32'd5340245;
            8:  return 32'd2670163;
            9:  return 32'd1335087;
            10: return 32'd667544;
            11: return 32'd333772;
            12: return 32'd166886;
            13: return 32'd83443;
            14: return 32'd41722;
            15: return 32'd20861;
            16: return 32'd10430;
            17: return 32'd5215;
            18: return 32'd2608;
            19: return 32'd1304;
            20: return 32'd652;
            21: return 32'd326;
            22: return 32'd163;
            23: return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

    // One restoring step of both long divisions by the segment count.
    function automatic div_t div_step(input div_t d, input logic [10:0] seg,
                                      input logic uv_en, input logic uv_bit);
        div_t       o;
        logic [11:0] rr;
        logic [11:0] ru;
        o  = d;
        rr = {d.rem_ph, 1'b0};
        if (rr >= {1'b0, seg}) begin
            o.rem_ph = 11'(rr - {1'b0, seg});
            o.q_ph   = {d.q_ph[PHASE_BITS-2:0], 1'b1};
        end else begin
            o.rem_ph = rr[10:0];
            o.q_ph   = {d.q_ph[PHASE_BITS-2:0], 1'b0};
        end
        ru = {d.rem_uv, uv_bit};
        if (uv_en) begin
            if (ru >= {1'b0, seg}) begin
                o.rem_uv = 11'(ru - {1'b0, seg});
                o.q_uv   = {d.q_uv[UV_BITS-1:0], 1'b1};
            end else begin
                o.rem_uv = ru[10:0];
                o.q_uv   = {d.q_uv[UV_BITS-1:0], 1'b0};
            end
        end
        return o;
    endfunction

    function automatic cord_t cordic_step(input cord_t c, input int unsigned i);
        cord_t              o;
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic signed [33:0] a;
        xs = c.x >>> i;
        ys = c.y >>> i;
        a  = $signed({2'b00, atan_turn(i)});
        o.quad = c.quad;
        if (!c.z[33]) begin
            o.x = c.x - ys;
            o.y = c.y + xs;
            o.z = c.z - a;
        end else begin
            o.x = c.x + ys;
            o.y = c.y - xs;
            o.z = c.z + a;
        end
        return o;
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [18:0] t);
        if (t > 19'sd16384) begin
            return TRIG_ONE;
        end else if (t < -19'sd16384) begin
            return -TRIG_ONE;
        end
        return t[15:0];
    endfunction

    // Round a Q2.30 CORDIC output to Q1.14.
    function automatic logic signed [15:0] round_trig(input logic signed [32:0] x);
        logic signed [33:0] s;
        s = 34'(x) + 34'sd32768;
        return clamp_q14(19'(s >>> 16));
    endfunction

endpackage

// ----- sv/torus_vertex_generator_core.sv -----
// ---------------------------------------------------------------------------
// Torus vertex generator core
// Pipelined generator of torus vertex position, normal, UV and index.
// ---------------------------------------------------------------------------
//  channel  direction  tdata fields (lowest bit first)
//  s_       in         ring_index[10:0], tube_index[21:11], zero pad to 24
//  m_       out        pos_x, pos_y, pos_z, normal_x/y/z, tex_u, tex_v,
//                      vertex_number (160 bits)
//  cfg_wr_  in         major/minor radius, ring/tube segments by index
//
//  One beat enters per cycle while the output is not stalled; the pipeline depth
//  is set by the 32 radix-2 division steps for the phase and the CORDIC rotations.
//  Reset (aresetn low, synchronous) empties the pipeline and loads register
//  defaults. A stalled output holds the whole pipeline in place; s_tready
//  drops while a finished beat waits on m_tready and while in reset.
// ---------------------------------------------------------------------------
`include "torus_vertex_generator_core_defines.svh"

module torus_vertex_generator_core
    import tvg_pkg::*;
#(
    parameter int MAX_SEGMENTS  = 1024,
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // ring_index, tube_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // pos_x, pos_y, pos_z, normal_x, normal_y,
                                    // normal_z, tex_u, tex_v, vertex_number
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_index,
    input  logic [15:0]  cfg_wr_data
);

    localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int DS   = PHASE_BITS;       // last division stage
    localparam int QS   = DS + 1;           // quadrant reduction
    localparam int RS   = QS + NSTG + 1;    // rounding and quadrant mapping
    localparam int PA   = RS + 1;           // first products
    localparam int OS   = PA + 1;           // output register
    localparam int L    = OS + 1;
    localparam logic [16:0] MAX_SEG = 17'(MAX_SEGMENTS);

    // Configuration registers
    logic [15:0] major_radius_reg, major_radius_next;
    logic [15:0] minor_radius_reg, minor_radius_next;
    logic [10:0] ring_segments_reg, ring_segments_next;
    logic [10:0] tube_segments_reg, tube_segments_next;

    always_comb begin
        major_radius_next  = major_radius_reg;
        minor_radius_next  = minor_radius_reg;
        ring_segments_next = ring_segments_reg;
        tube_segments_next = tube_segments_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MAJOR_RADIUS:  major_radius_next  = cfg_wr_data;
                REG_MINOR_RADIUS:  minor_radius_next  = cfg_wr_data;
                REG_RING_SEGMENTS: ring_segments_next = cfg_wr_data[10:0];
                REG_TUBE_SEGMENTS: tube_segments_next = cfg_wr_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_radius_reg  <= 16'd256;
            minor_radius_reg  <= 16'd64;
            ring_segments_reg <= 11'd32;
            tube_segments_reg <= 11'd16;
        end else begin
            major_radius_reg  <= major_radius_next;
            minor_radius_reg  <= minor_radius_next;
            ring_segments_reg <= ring_segments_next;
            tube_segments_reg <= tube_segments_next;
        end
    end

    // Effective segment counts: zero acts as one, clip at MAX_SEGMENTS.
    function automatic logic [10:0] eff_seg(input logic [10:0] r);
        if (r == 11'd0) begin
            return 11'd1;
        end else if ({6'd0, r} > MAX_SEG) begin
            return MAX_SEG[10:0];
        end
        return r;
    endfunction

    logic [10:0] rs_eff, ts_eff;
    assign rs_eff = eff_seg(ring_segments_reg);
    assign ts_eff = eff_seg(tube_segments_reg);

    // Global advance: move every stage unless a finished beat is blocked.
    logic         ce;
    logic [L-1:0] valid_reg, valid_next;

    assign ce         = !m_tvalid || m_tready;
    assign s_tready   = ce && aresetn;
    assign m_tvalid   = valid_reg[OS];
    assign valid_next = {valid_reg[L-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    // Stage 0: clamp indices and seed the divisions.
    logic [10:0] ri_in, ti_in, ri_c, ti_c;
    logic [10:0] ri_reg, ti_reg;
    div_t        ring_div_reg [0:DS];
    div_t        tube_div_reg [0:DS];
    div_t        ring_div_next [0:DS];
    div_t        tube_div_next [0:DS];

    assign ri_in = s_tdata[10:0];
    assign ti_in = s_tdata[21:11];
    assign ri_c  = (ri_in > rs_eff) ? rs_eff : ri_in;
    assign ti_c  = (ti_in > ts_eff) ? ts_eff : ti_in;

    // A full turn gives phase zero; the top quotient bit goes straight to the UV.
    assign ring_div_next[0] = '{rem_ph: (ri_c == rs_eff) ? 11'd0 : ri_c,
                                q_ph:   '0,
                                rem_uv: (ri_c == rs_eff) ? 11'd0 : ri_c,
                                q_uv:   {{UV_BITS{1'b0}}, (ri_c == rs_eff)}};
    assign tube_div_next[0] = '{rem_ph: (ti_c == ts_eff) ? 11'd0 : ti_c,
                                q_ph:   '0,
                                rem_uv: (ti_c == ts_eff) ? 11'd0 : ti_c,
                                q_uv:   {{UV_BITS{1'b0}}, (ti_c == ts_eff)}};

    // Division stages: one quotient bit of phase a stage, and of UV in the first UV_BITS stages.
    logic [UV_BITS-1:0] half_rs, half_ts;
    assign half_rs = {{(UV_BITS-10){1'b0}}, rs_eff[10:1]};
    assign half_ts = {{(UV_BITS-10){1'b0}}, ts_eff[10:1]};

    genvar k;
    generate
        for (k = 1; k <= DS; k++) begin : g_div
            if (k <= UV_BITS) begin : g_uv
                assign ring_div_next[k] = div_step(ring_div_reg[k-1], rs_eff, 1'b1,
                                                   half_rs[UV_BITS-k]);
                assign tube_div_next[k] = div_step(tube_div_reg[k-1], ts_eff, 1'b1,
                                                   half_ts[UV_BITS-k]);
            end else begin : g_ph
                assign ring_div_next[k] = div_step(ring_div_reg[k-1], rs_eff, 1'b0, 1'b0);
                assign tube_div_next[k] = div_step(tube_div_reg[k-1], ts_eff, 1'b0, 1'b0);
            end
        end
    endgenerate

    // Vertex number alongside the divisions.
    logic [20:0] vn_reg [1:DS];
    logic [22:0] vn_full;
    assign vn_full = 23'(ri_reg) * 23'({1'b0, ts_eff} + 12'd1) + 23'(ti_reg);

    // Quadrant reduction and CORDIC.
    cord_t cr_reg [QS:QS+NSTG];
    cord_t ct_reg [QS:QS+NSTG];
    cord_t cr_next [QS:QS+NSTG];
    cord_t ct_next [QS:QS+NSTG];
    side_t side_reg [QS:PA];
    side_t side_next;

    function automatic cord_t cordic_seed(input logic [31:0] phase);
        cord_t       c;
        logic [31:0] ph;
        logic [31:0] d;
        ph     = phase + EIGHTH_TURN;
        c.quad = ph[31:30];
        d      = phase - {c.quad, 30'd0};
        c.x    = CORDIC_GAIN;
        c.y    = '0;
        c.z    = 34'($signed(d));
        return c;
    endfunction

    assign cr_next[QS] = cordic_seed(ring_div_reg[DS].q_ph);
    assign ct_next[QS] = cordic_seed(tube_div_reg[DS].q_ph);
    assign side_next   = '{u: ring_div_reg[DS].q_uv, v: tube_div_reg[DS].q_uv,
                           vn: vn_reg[DS]};

    genvar c;
    generate
        for (c = 0; c < NSTG; c++) begin : g_cordic
            assign cr_next[QS+c+1] = cordic_step(cr_reg[QS+c], c);
            assign ct_next[QS+c+1] = cordic_step(ct_reg[QS+c], c);
        end
    endgenerate

    // Rounding and quadrant mapping.
    function automatic logic [31:0] map_quad(input cord_t v);
        logic signed [15:0] cx, sy;
        cx = round_trig(v.x);
        sy = round_trig(v.y);
        case (v.quad)
            QUAD_0:  return {cx, sy};
            QUAD_1:  return {-sy, cx};
            QUAD_2:  return {-cx, -sy};
            QUAD_3:  return {sy, -cx};
            default: return {cx, sy};
        endcase
    endfunction

    trig_t       trig_reg, trig_next;
    logic [31:0] rmap, tmap;
    assign rmap = map_quad(cr_reg[QS+NSTG]);
    assign tmap = map_quad(ct_reg[QS+NSTG]);
    assign trig_next = '{cp: rmap[31:16], sp: rmap[15:0], ct: tmap[31:16], st: tmap[15:0]};

    // First products: distance from the axis, normal terms, height.
    pa_t pa_reg, pa_next;
    always_comb begin
        pa_next.ring = $signed({3'b000, major_radius_reg, 14'd0})
                     + $signed({1'b0, minor_radius_reg}) * trig_reg.ct;
        pa_next.cp   = trig_reg.cp;
        pa_next.sp   = trig_reg.sp;
        pa_next.st   = trig_reg.st;
        pa_next.nx_p = trig_reg.ct * trig_reg.cp;
        pa_next.nz_p = trig_reg.ct * trig_reg.sp;
        pa_next.py_p = $signed({1'b0, minor_radius_reg}) * trig_reg.st;
    end

    // Output stage: ring products and rounding.
    logic signed [48:0] px_full, pz_full;
    logic signed [32:0] py_full, nx_full, nz_full;
    logic [18:0] pos_x_reg, pos_y_reg, pos_z_reg, pos_x_next, pos_y_next, pos_z_next;
    logic [15:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic [15:0] normal_x_next, normal_y_next, normal_z_next;
    side_t       out_side_reg;

    assign px_full = pa_reg.ring * pa_reg.cp + 49'sd134217728;
    assign pz_full = pa_reg.ring * pa_reg.sp + 49'sd134217728;
    assign py_full = pa_reg.py_p + 33'sd8192;
    assign nx_full = 33'(pa_reg.nx_p) + 33'sd8192;
    assign nz_full = 33'(pa_reg.nz_p) + 33'sd8192;

    assign pos_x_next    = px_full[46:28];
    assign pos_y_next    = py_full[32:14];
    assign pos_z_next    = pz_full[46:28];
    assign normal_x_next = clamp_q14(nx_full[32:14]);
    assign normal_y_next = pa_reg.st;
    assign normal_z_next = clamp_q14(nz_full[32:14]);

    // Payload registers: advance with ce, no reset.
    always_ff @(posedge aclk) begin
        if (ce) begin
            ri_reg          <= ri_c;
            ti_reg          <= ti_c;
            ring_div_reg[0] <= ring_div_next[0];
            tube_div_reg[0] <= tube_div_next[0];
            for (int i = 1; i <= DS; i++) begin
                ring_div_reg[i] <= ring_div_next[i];
                tube_div_reg[i] <= tube_div_next[i];
            end
            vn_reg[1] <= vn_full[20:0];
            for (int i = 2; i <= DS; i++) begin
                vn_reg[i] <= vn_reg[i-1];
            end
            for (int i = QS; i <= QS + NSTG; i++) begin
                cr_reg[i] <= cr_next[i];
                ct_reg[i] <= ct_next[i];
            end
            side_reg[QS] <= side_next;
            for (int i = QS + 1; i <= PA; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            trig_reg     <= trig_next;
            pa_reg       <= pa_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            normal_x_reg <= normal_x_next;
            normal_y_reg <= normal_y_next;
            normal_z_reg <= normal_z_next;
            out_side_reg <= side_reg[PA];
        end
    end

    assign m_tdata = {out_side_reg.vn, out_side_reg.v, out_side_reg.u,
                      normal_z_reg, normal_y_reg, normal_x_reg,
                      pos_z_reg, pos_y_reg, pos_x_reg};

    // Assertions
    `TVG_ASSERT_ALWAYS(a_empty_after_reset, !aresetn |=> !m_tvalid,
        "pipeline not empty after reset")
    `TVG_ASSERT(a_tex_u_range, m_tvalid |-> out_side_reg.u <= 17'd65536,
        "tex_u above one")
    `TVG_ASSERT(a_normal_y_range,
        m_tvalid |-> ($signed(normal_y_reg) <= TRIG_ONE && $signed(normal_y_reg) >= -TRIG_ONE),
        "normal_y outside unit range")
    `TVG_ASSERT(a_residual_range,
        valid_reg[QS] |-> (cr_reg[QS].z < 34'sd536870912 && cr_reg[QS].z >= -34'sd536870912),
        "ring residual angle outside an eighth turn")

endmodule
